// File: hw/rtl/mpd_pkg.sv
// Shared types and constants for the 2x2 priority mask downsampler.
// Holds pixel class codes, register indexes and default geometry limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int DIM_W    = 14;
   localparam int LABEL_W  = 8;
   localparam int FWIDTH_W = 12;
   localparam int FHEIGHT_W = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_HOLE_LABEL   = 3'd2,
      CSR_BACK_LABEL   = 3'd3,
      CSR_SEARCH_LABEL = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_SEARCH = 2'd0,
      CLS_BACK   = 2'd1,
      CLS_HOLE   = 2'd2
   } class_type;

   function automatic class_type class_max(input class_type a, input class_type b);
      class_type r;
      r = (a > b) ? a : b;
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mpd_line_store.sv
// Line store holding the class of each top-row pair of a block row.
// Synchronous memory, one write and one read port, registered read data.
// Depends on mpd_pkg for the class type.
`timescale 1ns / 1ps
`default_nettype none

module mpd_line_store
   import mpd_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH / 2,
   parameter int IDX_W = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire class_type        wr_class,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   output class_type             rd_class
);

   class_type store_ff [DEPTH];
   class_type rd_class_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_class;
      end
      if (rd_en) begin
         rd_class_ff <= store_ff[rd_idx];
      end
   end

   assign rd_class = rd_class_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mask_priority_downsample_2x2.sv
// A result passes through the block stage and the result register before rsp_tvalid.
// Throughput: one pixel per clock unless stalled; at most one line store access per pixel.
// A stalled result stops input only once the block stage behind it is also full.
// Reset clears counters, labels and geometry to defaults and empties the pipeline.
// The line store is not cleared; an odd row only reads pairs written by the row above.
// Depends on mpd_pkg and mpd_line_store.
`timescale 1ns / 1ps
`default_nettype none

module mask_priority_downsample_2x2
   import mpd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: [7:0] in_label
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [LABEL_W-1:0]    req_tdata,
   // rsp_tdata: [7:0] out_label
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [LABEL_W-1:0]         rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COL_W = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
   localparam int ROW_W = ($clog2(MAX_HEIGHT) < 1) ? 1 : $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int IDX_W = COL_W - 1;

   logic [FWIDTH_W-1:0]  frame_width_ff;
   logic [FHEIGHT_W-1:0] frame_height_ff;
   logic [LABEL_W-1:0]   hole_label_ff;
   logic [LABEL_W-1:0]   back_label_ff;
   logic [LABEL_W-1:0]   search_label_ff;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   class_type        left_ff, left_in;

   logic      s1_valid_ff;
   logic      s1_odd_ff;
   logic      s1_last_ff;
   class_type s1_pair_ff;

   logic               rsp_valid_ff;
   logic [LABEL_W-1:0] rsp_label_ff;
   logic               rsp_last_ff;

   logic [DIM_W-1:0] w_eff, h_eff, fw_ext, fh_ext;
   logic             req_accept, csr_accept, out_can, s1_adv, geom_wr;
   logic             last_col, last_row, pair_done, row_odd, emit;
   logic             st_we, st_re;
   logic [IDX_W-1:0] st_idx;
   class_type        cls, pair, rd_class, blk;
   logic [LABEL_W-1:0] blk_label;

   // Geometry clamp.
   always_comb begin
      fw_ext = DIM_W'(frame_width_ff);
      fh_ext = DIM_W'(frame_height_ff);
      if (fw_ext == '0) begin
         w_eff = DIM_W'(1);
      end else if (fw_ext > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (fh_ext == '0) begin
         h_eff = DIM_W'(1);
      end else if (fh_ext > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext;
      end
   end

   assign out_can    = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = out_can;
   assign req_tready = !s1_valid_ff || out_can;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign geom_wr    = csr_accept && (csr_index inside {CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT});

   // Classify and pair the incoming pixel.
   always_comb begin
      if (req_tdata == hole_label_ff) begin
         cls = CLS_HOLE;
      end else if (req_tdata == back_label_ff) begin
         cls = CLS_BACK;
      end else begin
         cls = CLS_SEARCH;
      end
      last_col = (DIM_W'(col_ff) + DIM_W'(1)) >= w_eff;
      last_row = (DIM_W'(row_ff) + DIM_W'(1)) >= h_eff;
      row_odd  = row_ff[0];
      left_in  = left_ff;
      if (!col_ff[0]) begin
         pair      = cls;
         pair_done = last_col;
         left_in   = cls;
      end else begin
         pair      = class_max(left_ff, cls);
         pair_done = 1'b1;
      end
      emit   = pair_done && (row_odd || last_row);
      st_we  = req_accept && pair_done && !row_odd && !last_row;
      st_re  = req_accept && pair_done && row_odd;
      st_idx = col_ff[COL_W-1:1];
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end
   end

   mpd_line_store #(
      .DEPTH (STORE_DEPTH),
      .IDX_W (IDX_W)
   ) u_line_store (
      .clock    (clock),
      .wr_en    (st_we),
      .wr_idx   (st_idx),
      .wr_class (pair),
      .rd_en    (st_re),
      .rd_idx   (st_idx),
      .rd_class (rd_class)
   );

   // Merge with the stored top pair and map to a label.
   always_comb begin
      blk = s1_odd_ff ? class_max(rd_class, s1_pair_ff) : s1_pair_ff;
      case (blk)
         CLS_HOLE: begin
            blk_label = hole_label_ff;
         end
         CLS_BACK: begin
            blk_label = back_label_ff;
         end
         default: begin
            blk_label = search_label_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FWIDTH_W'(640);
         frame_height_ff <= FHEIGHT_W'(480);
         hole_label_ff   <= LABEL_W'(0);
         back_label_ff   <= LABEL_W'(1);
         search_label_ff <= LABEL_W'(2);
         col_ff          <= '0;
         row_ff          <= '0;
         left_ff         <= CLS_SEARCH;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (geom_wr) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (req_accept) begin
            left_ff <= left_in;
         end
         if (csr_accept) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  frame_width_ff <= csr_data[FWIDTH_W-1:0];
               end
               CSR_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_data[FHEIGHT_W-1:0];
               end
               CSR_HOLE_LABEL: begin
                  hole_label_ff <= csr_data[LABEL_W-1:0];
               end
               CSR_BACK_LABEL: begin
                  back_label_ff <= csr_data[LABEL_W-1:0];
               end
               CSR_SEARCH_LABEL: begin
                  search_label_ff <= csr_data[LABEL_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_accept) begin
            s1_valid_ff <= emit;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_can) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_odd_ff  <= row_odd;
         s1_pair_ff <= pair;
         s1_last_ff <= last_col && last_row;
      end
      if (out_can && s1_valid_ff) begin
         rsp_label_ff <= blk_label;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_label_ff;
   assign rsp_tlast  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      DIM_W'(col_ff) < w_eff)
      else $error("column counter beyond frame width");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_can) |-> !req_accept)
      else $error("pixel accepted while block stage is stalled");

   assert property (@(posedge clock) disable iff (reset)
      !(st_we && st_re))
      else $error("line store written and read in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_can) |=> (s1_valid_ff && $stable(rd_class)))
      else $error("stalled block lost its stored pair");

endmodule

`default_nettype wire

// File: bench/mpd_checker.sv
// Scoreboard for the 2x2 priority mask downsampler: watches the pixel, result and CSR channels.
// Predicts each block label from its own copy of the registers, line store and counters.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_checker
   import mpd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [LABEL_W-1:0]    req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [LABEL_W-1:0]    rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatches,
   output int                    pending
);

   localparam int PAIR_SLOTS = (MAX_WIDTH + 1) / 2;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               last;
   } block_label_type;

   block_label_type expected_blocks[$];

   class_type            top_pair_class [PAIR_SLOTS];
   class_type            even_pixel_class;
   int unsigned          row_pos;
   int unsigned          col_pos;
   logic [FWIDTH_W-1:0]  width_reg;
   logic [FHEIGHT_W-1:0] height_reg;
   logic [LABEL_W-1:0]   hole_lbl;
   logic [LABEL_W-1:0]   back_lbl;
   logic [LABEL_W-1:0]   search_lbl;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic int unsigned effective_dim(input int unsigned value, input int unsigned limit);
      if (value == 0) return 1;
      if (value > limit) return limit;
      return value;
   endfunction

   function automatic class_type pixel_class(input logic [LABEL_W-1:0] px);
      if (px == hole_lbl) return CLS_HOLE;
      if (px == back_lbl) return CLS_BACK;
      return CLS_SEARCH;
   endfunction

   function automatic class_type stronger(input class_type a, input class_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [LABEL_W-1:0] class_to_label(input class_type c);
      if (c == CLS_HOLE) return hole_lbl;
      if (c == CLS_BACK) return back_lbl;
      return search_lbl;
   endfunction

   task automatic downsample_pixel(input logic [LABEL_W-1:0] px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     slot;
      class_type       cls;
      class_type       pair;
      class_type       blk;
      logic            last_col;
      logic            last_row;
      logic            pair_done;
      block_label_type result;
      w = effective_dim(width_reg, MAX_WIDTH);
      h = effective_dim(height_reg, MAX_HEIGHT);
      cls = pixel_class(px);
      last_col = (col_pos + 1) >= w;
      last_row = (row_pos + 1) >= h;
      slot = col_pos >> 1;
      if (slot >= PAIR_SLOTS) slot = PAIR_SLOTS - 1;
      pair = CLS_SEARCH;
      pair_done = 1'b0;
      if (col_pos[0] == 1'b0) begin
         even_pixel_class = cls;
         if (last_col) begin
            pair = cls;
            pair_done = 1'b1;
         end
      end else begin
         pair = stronger(even_pixel_class, cls);
         pair_done = 1'b1;
      end
      if (pair_done) begin
         if (row_pos[0] == 1'b0 && !last_row) begin
            top_pair_class[slot] = pair;
         end else begin
            blk = pair;
            if (row_pos[0] == 1'b1) blk = stronger(top_pair_class[slot], pair);
            result.label = class_to_label(blk);
            result.last  = last_col && last_row;
            expected_blocks.push_back(result);
         end
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   always @(posedge clock) begin
      block_label_type want;
      if (reset) begin
         expected_blocks.delete();
         even_pixel_class = CLS_SEARCH;
         row_pos    = 0;
         col_pos    = 0;
         width_reg  = FWIDTH_W'(640);
         height_reg = FHEIGHT_W'(480);
         hole_lbl   = 8'd0;
         back_lbl   = 8'd1;
         search_lbl = 8'd2;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH: begin
                  width_reg = csr_data[FWIDTH_W-1:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               CSR_FRAME_HEIGHT: begin
                  height_reg = csr_data[FHEIGHT_W-1:0];
                  row_pos = 0;
                  col_pos = 0;
               end
               CSR_HOLE_LABEL:   hole_lbl   = csr_data[LABEL_W-1:0];
               CSR_BACK_LABEL:   back_lbl   = csr_data[LABEL_W-1:0];
               CSR_SEARCH_LABEL: search_lbl = csr_data[LABEL_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) downsample_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result label %0h last %0b with nothing expected",
                           $realtime, rsp_tdata, rsp_tlast);
               mismatches = mismatches + 1;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata !== want.label || rsp_tlast !== want.last) begin
                  if (mismatches < 10)
                     $display("%0t: expected label %0h last %0b, got label %0h last %0b",
                              $realtime, want.label, want.last, rsp_tdata, rsp_tlast);
                  mismatches = mismatches + 1;
               end
            end
         end
      end
      pending = expected_blocks.size();
   end

endmodule

// File: bench/tb_mask_priority_downsample_2x2.sv
// Top of the 2x2 priority mask downsampler bench: clock, reset, pixel frames and CSR setup.
// Checking is done by mpd_checker; this module drives stimulus and reports the verdict.
// Depends on mpd_pkg, mask_priority_downsample_2x2 and mpd_checker.
`timescale 1ns / 1ps

module tb_mask_priority_downsample_2x2;
   import mpd_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PIXELS = 540;
   localparam int LONG_PIXELS   = 160;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [LABEL_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [LABEL_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int                    mismatches;
   int                    outstanding;
   int                    send_gap_pct = 10;
   int                    rsp_gap_pct = 51;
   int                    random_pixels = 0;
   int                    stall_cycles = 0;
   logic [LABEL_W-1:0]    hole_now = 8'd0;
   logic [LABEL_W-1:0]    back_now = 8'd1;
   logic [LABEL_W-1:0]    search_now = 8'd2;

   always #4 clock = ~clock;

   mask_priority_downsample_2x2 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mpd_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (outstanding)
   );

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rsp_gap_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Leaves csr_valid high; the caller drops it once the burst of writes is done.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic setup(input logic geom, input logic [CSR_DATA_W-1:0] w_data,
                        input logic [CSR_DATA_W-1:0] h_data, input logic labels,
                        input logic [CSR_DATA_W-1:0] hole_data,
                        input logic [CSR_DATA_W-1:0] back_data,
                        input logic [CSR_DATA_W-1:0] search_data);
      if (geom) begin
         write_reg(CSR_FRAME_WIDTH, w_data);
         write_reg(CSR_FRAME_HEIGHT, h_data);
      end
      if (labels) begin
         write_reg(CSR_HOLE_LABEL, hole_data);
         write_reg(CSR_BACK_LABEL, back_data);
         write_reg(CSR_SEARCH_LABEL, search_data);
         hole_now   = hole_data[LABEL_W-1:0];
         back_now   = back_data[LABEL_W-1:0];
         search_now = search_data[LABEL_W-1:0];
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_pixel(input logic [LABEL_W-1:0] px);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, drain all results, then idle for SETTLE_CYCLES for pixels that produce none.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [LABEL_W-1:0] pick_pixel(input int hole_pct, input int back_pct);
      int r;
      r = $urandom_range(99);
      if (r < hole_pct) return hole_now;
      if (r < hole_pct + back_pct) return back_now;
      if (r < hole_pct + back_pct + 15) return search_now;
      return LABEL_W'($urandom_range(255));
   endfunction

   task automatic long_frame(input logic [CSR_DATA_W-1:0] w_data,
                             input logic [CSR_DATA_W-1:0] h_data, input int count);
      setup(1'b1, w_data, h_data, 1'b0, '0, '0, '0);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel(20, 20));
      settle();
   endtask

   task automatic random_labels(output logic [CSR_DATA_W-1:0] hl,
                                output logic [CSR_DATA_W-1:0] bl,
                                output logic [CSR_DATA_W-1:0] sl);
      logic [LABEL_W-1:0] h;
      h  = LABEL_W'($urandom_range(255));
      hl = {5'($urandom_range(31)), h};
      bl = {5'($urandom_range(31)),
            ($urandom_range(3) == 0) ? h : LABEL_W'($urandom_range(255))};
      sl = {5'($urandom_range(31)), LABEL_W'($urandom_range(255))};
   endtask

   task automatic random_frame();
      int                    w;
      int                    h;
      int                    total;
      int                    split;
      int                    hole_pct;
      int                    back_pct;
      logic                  relabel;
      logic [CSR_DATA_W-1:0] hl;
      logic [CSR_DATA_W-1:0] bl;
      logic [CSR_DATA_W-1:0] sl;
      w = ($urandom_range(9) == 0) ? $urandom_range(11, 33) : $urandom_range(0, 10);
      h = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 8);
      relabel = ($urandom_range(2) == 0);
      random_labels(hl, bl, sl);
      setup(1'b1, {1'($urandom_range(1)), FWIDTH_W'(w)}, CSR_DATA_W'(h), relabel, hl, bl, sl);
      total = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      split = (total > 1 && $urandom_range(3) == 0) ? $urandom_range(1, total - 1) : -1;
      hole_pct = $urandom_range(0, 30);
      back_pct = $urandom_range(0, 30);
      for (int i = 0; i < total; i++) begin
         if (i == split) begin
            settle();
            random_labels(hl, bl, sl);
            setup(1'b0, '0, '0, 1'b1, hl, bl, sl);
         end
         send_pixel(pick_pixel(hole_pct, back_pct));
      end
      settle();
      random_pixels = random_pixels + total;
   endtask

   initial begin
      logic [LABEL_W-1:0] odd_frame [9];
      odd_frame = '{8'h55, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'h55};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero geometry reads as a single pixel
      setup(1'b1, '0, '0, 1'b1, 13'd0, 13'd1, 13'd2);
      send_pixel(8'hFF);
      settle();

      // odd width and height, hole and back labels equal
      setup(1'b1, 13'd3, 13'd3, 1'b1, 13'h55, 13'h55, 13'hAA);
      foreach (odd_frame[i]) send_pixel(odd_frame[i]);
      settle();

      setup(1'b1, 13'd2, 13'd2, 1'b1, 13'd0, 13'd1, 13'd2);
      send_pixel(8'd1);
      send_pixel(8'd2);
      send_pixel(8'd3);
      send_pixel(8'hFF);
      settle();

      // relabel between the rows of a block; stored pair classes stay
      setup(1'b1, 13'd4, 13'd2, 1'b0, '0, '0, '0);
      send_pixel(8'd2);
      send_pixel(8'd2);
      send_pixel(8'd0);
      send_pixel(8'd1);
      settle();
      setup(1'b0, '0, '0, 1'b1, 13'd2, 13'd3, 13'd4);
      send_pixel(8'd7);
      send_pixel(8'd7);
      send_pixel(8'd3);
      send_pixel(8'd9);
      settle();

      for (int ph = 0; ph < 3; ph++) begin
         send_gap_pct = (ph == 0) ? 10 : (ph == 1) ? 51 : 0;
         rsp_gap_pct  = (ph == 0) ? 51 : (ph == 1) ? 10 : 0;
         case (ph)
            0: long_frame(13'd1, 13'd4096, LONG_PIXELS);
            1: long_frame(13'd2048, 13'd1, LONG_PIXELS);
            default: long_frame(13'hFFF, 13'h1FFF, LONG_PIXELS);
         endcase
         while (random_pixels < (ph + 1) * RANDOM_PIXELS / 3) random_frame();
      end

      while (outstanding != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_line_store.sv
hw/rtl/mask_priority_downsample_2x2.sv
bench/mpd_checker.sv
bench/tb_mask_priority_downsample_2x2.sv
